>>> rtl/png_row_unfilter_top_macros.svh
// assertion macros for the png row unfilter rtl
`ifndef PNG_ROW_UNFILTER_TOP_MACROS_SVH
`define PNG_ROW_UNFILTER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PNGUNF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define PNGUNF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition never holds
`define PNGUNF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> rtl/pngunf_pkg.sv
// package with types and constants for the png row unfilter
`default_nettype none

package pngunf_pkg;

  localparam int ROW_BYTES_W   = 14;
  localparam int STEP_W        = 4;
  localparam int MAX_ROW_BYTES = 8192;
  localparam int MAX_STEP      = 8;
  localparam int HIST_DEPTH    = 8;
  localparam int HIST_W        = 3;

  // configuration register indexes
  localparam logic [0:0] REG_ROW_BYTES  = 1'b0;
  localparam logic [0:0] REG_PIXEL_STEP = 1'b1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  localparam logic [7:0] FILT_CODE_MAX = 8'd4;

  // neighbours handed to the reconstruction unit
  typedef struct packed {
    filt_t      filt;
    logic [7:0] left;
    logic [7:0] up;
    logic [7:0] corner;
  } pred_in_t;

endpackage

`default_nettype wire

>>> rtl/pngunf_recon.sv
// predictor and adder for one filtered byte
`default_nettype none

module pngunf_recon (
  input  pngunf_pkg::pred_in_t pred_in,
  input  logic [7:0]           byte_in,
  output logic [7:0]           rec
);
  import pngunf_pkg::*;

  logic signed [9:0] a_s, b_s, c_s;
  logic signed [9:0] pa_raw, pb_raw, pc_raw;
  logic        [9:0] pa, pb, pc;
  logic        [7:0] paeth;
  logic        [8:0] avg_sum;
  logic        [7:0] pred;

  assign a_s = signed'({2'b00, pred_in.left});
  assign b_s = signed'({2'b00, pred_in.up});
  assign c_s = signed'({2'b00, pred_in.corner});

  // distances of p = a + b - c to a, b and c
  assign pa_raw = b_s - c_s;
  assign pb_raw = a_s - c_s;
  assign pc_raw = a_s + b_s - c_s - c_s;
  assign pa = (pa_raw < 0) ? 10'(-pa_raw) : 10'(pa_raw);
  assign pb = (pb_raw < 0) ? 10'(-pb_raw) : 10'(pb_raw);
  assign pc = (pc_raw < 0) ? 10'(-pc_raw) : 10'(pc_raw);

  always_comb begin
    priority if (pa <= pb && pa <= pc) begin
      paeth = pred_in.left;
    end else if (pb <= pc) begin
      paeth = pred_in.up;
    end else begin
      paeth = pred_in.corner;
    end
  end

  assign avg_sum = {1'b0, pred_in.left} + {1'b0, pred_in.up};

  always_comb begin
    unique case (pred_in.filt)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = pred_in.left;
      FILT_UP:    pred = pred_in.up;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase
  end

  assign rec = byte_in + pred;

endmodule

`default_nettype wire

>>> rtl/png_row_unfilter_top.sv
// top level of the png row unfilter: control, line store and output register
//
//  channel | direction | tdata            | tlast   | tuser
//  in_     | slave     | [7:0] byte_in    | -       | [0] image_start
//  out_    | master    | [7:0] byte_out   | row_end | [0] bad_filter
//  cfg_    | write     | cfg_index 0: row_bytes, 1: pixel_step (cfg_data)
//
// one item per cycle unless the output stalls; two pipeline steps from accept to
// out_tvalid: the line store read is issued when the item is accepted, the byte
// is rebuilt and written back as it leaves the rebuild stage, then held in the
// output register. a bad filter code gives an error result; other codes and dropped
// items give none. synchronous active-low reset; the line store is not cleared
// and needs no pass. a stalled output holds the rebuild stage, and in_tready
// falls only while both the rebuild stage and the output register are full.
`default_nettype none

`include "png_row_unfilter_top_macros.svh"

module png_row_unfilter_top #(
  parameter int MAX_ROW_BYTES = pngunf_pkg::MAX_ROW_BYTES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] byte_in
  input  logic [0:0]                         in_tuser,   // [0] image_start
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // [7:0] byte_out
  output logic                               out_tlast,
  output logic [0:0]                         out_tuser,  // [0] bad_filter
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [0:0]                         cfg_index,
  input  logic [pngunf_pkg::ROW_BYTES_W-1:0] cfg_data
);
  import pngunf_pkg::*;

  localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int LW = $clog2(MAX_ROW_BYTES + 1);
  localparam int CW = (LW > ROW_BYTES_W) ? LW : ROW_BYTES_W;
  localparam int PW = (AW > STEP_W) ? AW : STEP_W;
  localparam logic [CW-1:0]     MAX_LEN  = CW'(MAX_ROW_BYTES);
  localparam logic [STEP_W-1:0] STEP_CAP = STEP_W'(MAX_STEP);

  // configuration registers
  logic [ROW_BYTES_W-1:0] row_bytes_r;
  logic [STEP_W-1:0]      pixel_step_r;

  // row control state
  logic [AW-1:0] pos_r, pos_nxt;
  filt_t         filt_r, filt_nxt;
  logic          await_r, await_nxt;
  logic          first_r, first_nxt;
  logic          err_r, err_nxt;

  // state as seen by the item, after an image start
  logic [AW-1:0] st_pos;
  logic          st_await, st_first, st_err;

  // rebuild stage
  logic              s1_valid_r;
  logic              s1_err_r;
  logic [7:0]        s1_byte_r;
  logic [AW-1:0]     s1_pos_r;
  logic              s1_last_r;
  logic              s1_use_up_r;
  logic              s1_has_left_r;
  logic [HIST_W-1:0] s1_hp_r;
  logic [HIST_W-1:0] s1_wh_r;
  filt_t             s1_filt_r;

  // output register
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_bad_r;

  // line store and neighbour history
  logic [7:0] line_mem [MAX_ROW_BYTES];
  logic [7:0] mem_q_r;
  logic [7:0] left_hist_r   [HIST_DEPTH];
  logic [7:0] corner_hist_r [HIST_DEPTH];

  logic          in_fire, s1_adv;
  logic          load_s1, load_err, mem_rd_en, mem_wr_en;
  logic [CW-1:0] len_eff, pos_inc;
  logic [STEP_W-1:0] step_eff;
  logic [PW-1:0] pos_w, step_w, back_w;
  logic          has_left, row_last;
  pred_in_t      pred_in;
  logic [7:0]    up_val, rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r  <= ROW_BYTES_W'(1);
      pixel_step_r <= STEP_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_BYTES:  row_bytes_r  <= cfg_data;
        REG_PIXEL_STEP: pixel_step_r <= cfg_data[STEP_W-1:0];
        default:        row_bytes_r  <= row_bytes_r;
      endcase
    end
  end

  // effective row length and pixel step
  always_comb begin
    priority if (row_bytes_r == '0) begin
      len_eff = CW'(1);
    end else if (CW'(row_bytes_r) > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = CW'(row_bytes_r);
    end
    priority if (pixel_step_r == '0) begin
      step_eff = STEP_W'(1);
    end else if (pixel_step_r > STEP_CAP) begin
      step_eff = STEP_CAP;
    end else begin
      step_eff = pixel_step_r;
    end
  end

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign pos_inc  = CW'(pos_r) + CW'(1);
  assign row_last = (pos_inc >= len_eff);
  assign pos_w    = PW'(pos_r);
  assign step_w   = PW'(step_eff);
  assign back_w   = pos_w - step_w;
  assign has_left = (pos_w >= step_w);

  // image start resets the row state before the item is looked at
  always_comb begin
    if (in_tuser[0]) begin
      st_pos   = '0;
      st_await = 1'b1;
      st_first = 1'b1;
      st_err   = 1'b0;
    end else begin
      st_pos   = pos_r;
      st_await = await_r;
      st_first = first_r;
      st_err   = err_r;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    filt_nxt  = filt_r;
    await_nxt = await_r;
    first_nxt = first_r;
    err_nxt   = err_r;
    load_s1   = 1'b0;
    load_err  = 1'b0;
    mem_rd_en = 1'b0;
    if (in_fire) begin
      pos_nxt   = st_pos;
      await_nxt = st_await;
      first_nxt = st_first;
      err_nxt   = st_err;
      if (!st_err) begin
        if (st_await) begin
          if (in_tdata > FILT_CODE_MAX) begin
            err_nxt  = 1'b1;
            load_s1  = 1'b1;
            load_err = 1'b1;
          end else begin
            filt_nxt  = filt_t'(in_tdata[2:0]);
            await_nxt = 1'b0;
            pos_nxt   = '0;
          end
        end else begin
          // data byte: never carries an image start here
          load_s1   = 1'b1;
          mem_rd_en = 1'b1;
          if (row_last) begin
            await_nxt = 1'b1;
            first_nxt = 1'b0;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_inc[AW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      filt_r  <= FILT_NONE;
      await_r <= 1'b1;
      first_r <= 1'b1;
      err_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      filt_r  <= filt_nxt;
      await_r <= await_nxt;
      first_r <= first_nxt;
      err_r   <= err_nxt;
    end
  end

  // rebuild stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= load_s1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_s1) begin
      s1_err_r      <= load_err;
      s1_byte_r     <= in_tdata;
      s1_pos_r      <= pos_r;
      s1_last_r     <= row_last;
      s1_use_up_r   <= !first_r;
      s1_has_left_r <= has_left;
      s1_hp_r       <= back_w[HIST_W-1:0];
      s1_wh_r       <= pos_w[HIST_W-1:0];
      s1_filt_r     <= filt_r;
    end
  end

  // line store: read at accept, write back when the byte leaves the rebuild stage
  assign mem_wr_en = s1_adv && !s1_err_r;

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      line_mem[s1_pos_r] <= rec;
    end
    if (mem_rd_en) begin
      mem_q_r <= line_mem[pos_r];
    end
  end

  assign up_val         = s1_use_up_r ? mem_q_r : 8'd0;
  assign pred_in.filt   = s1_filt_r;
  assign pred_in.up     = up_val;
  assign pred_in.left   = s1_has_left_r ? left_hist_r[s1_hp_r] : 8'd0;
  assign pred_in.corner = (s1_has_left_r && s1_use_up_r) ? corner_hist_r[s1_hp_r] : 8'd0;

  pngunf_recon u_recon (
    .pred_in (pred_in),
    .byte_in (s1_byte_r),
    .rec     (rec)
  );

  // history of the last pixel's bytes, left and above
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      left_hist_r[s1_wh_r]   <= rec;
      corner_hist_r[s1_wh_r] <= up_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r <= s1_err_r ? 8'd0 : rec;
      out_last_r <= !s1_err_r && s1_last_r;
      out_bad_r  <= s1_err_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_byte_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_bad_r;

  `PNGUNF_ASSERT_NEVER(a_no_rw_same_entry,
    mem_rd_en && mem_wr_en && (pos_r == s1_pos_r),
    "line store read and write hit the same entry")
  `PNGUNF_ASSERT_IMPL(a_err_result_clean,
    out_valid_r && out_bad_r, (out_byte_r == 8'd0) && !out_last_r,
    "error item carries data or row end")
  `PNGUNF_ASSERT_IMPL(a_stall_only_when_full,
    !in_tready, s1_valid_r && out_valid_r && !out_tready,
    "input stalled without a full pipeline")
  `PNGUNF_ASSERT_NEXT(a_rebuild_holds,
    s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_pos_r) && $stable(s1_byte_r),
    "rebuild stage changed while stalled")

endmodule

`default_nettype wire

>>> test/tb_png_row_unfilter_top.sv
// testbench for png_row_unfilter_top: directed and random scanlines checked against a shadow model
`timescale 1ns / 100ps

module tb_png_row_unfilter_top;
  import pngunf_pkg::*;

  // shadow copies: LIVE follows accepted items, PLAN runs ahead with the generator
  localparam int LIVE = 0;
  localparam int PLAN = 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX = 10;
  localparam int LONG_CUT_BYTES = 40;

  // one input item and one result item as they travel on the streams
  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } stream_item_t;

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
    logic       bad;
  } pix_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [7:0]             out_tdata;
  logic                   out_tlast;
  logic [0:0]             out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [0:0]             cfg_index = '0;
  logic [ROW_BYTES_W-1:0] cfg_data = '0;

  png_row_unfilter_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // shadow state of the unfilter, one copy per index
  logic [ROW_BYTES_W-1:0] row_len_reg [2];
  logic [STEP_W-1:0]      step_reg [2];
  logic [7:0]             line_mem [2][MAX_ROW_BYTES];
  bit                     line_valid [2][MAX_ROW_BYTES];
  logic [7:0]             left_hist [2][HIST_DEPTH];
  logic [7:0]             corner_hist [2][HIST_DEPTH];
  int unsigned            col [2];
  filt_t                  row_filt [2];
  bit                     want_code [2];
  bit                     top_row [2];
  bit                     halted [2];

  stream_item_t queued_bytes [$];   // items waiting for the driver
  pix_result_t  rebuilt_due [$];    // reconstructed bytes still owed by the block

  int gap_pct = 0;
  int stall_pct = 0;
  int fed_bytes = 0;
  int mismatch_cnt = 0;
  bit in_took = 1'b0;

  stream_item_t took_item;
  pix_result_t  due_pix;
  pix_result_t  seen_pix;
  pix_result_t  sink_pix;
  stream_item_t next_item;

  function automatic void reset_shadow(input int c);
    row_len_reg[c] = ROW_BYTES_W'(1);
    step_reg[c]    = STEP_W'(1);
    for (int i = 0; i < MAX_ROW_BYTES; i++) begin
      line_valid[c][i] = 1'b0;
      line_mem[c][i]   = '0;
    end
    for (int i = 0; i < HIST_DEPTH; i++) begin
      left_hist[c][i]   = '0;
      corner_hist[c][i] = '0;
    end
    col[c]       = 0;
    row_filt[c]  = FILT_NONE;
    want_code[c] = 1'b1;
    top_row[c]   = 1'b1;
    halted[c]    = 1'b0;
  endfunction

  function automatic void set_reg(input int c, input logic [0:0] idx,
                                  input logic [ROW_BYTES_W-1:0] val);
    if (idx == REG_ROW_BYTES) row_len_reg[c] = val;
    else step_reg[c] = val[STEP_W-1:0];
  endfunction

  // zero reads as one, large values saturate
  function automatic int unsigned row_len_of(input int c);
    if (row_len_reg[c] == 0) return 1;
    if (row_len_reg[c] > MAX_ROW_BYTES) return MAX_ROW_BYTES;
    return row_len_reg[c];
  endfunction

  function automatic int unsigned px_step_of(input int c);
    if (step_reg[c] == 0) return 1;
    if (step_reg[c] > MAX_STEP) return MAX_STEP;
    return step_reg[c];
  endfunction

  function automatic logic [7:0] paeth_select(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] cc);
    int ia, ib, ic, p, da, db, dc;
    ia = a;
    ib = b;
    ic = cc;
    p  = ia + ib - ic;
    da = (p > ia) ? p - ia : ia - p;
    db = (p > ib) ? p - ib : ib - p;
    dc = (p > ic) ? p - ic : ic - p;
    if (da <= db && da <= dc) return a;
    return (db <= dc) ? b : cc;
  endfunction

  // advances one shadow copy by one item; returns 1 when the item yields a result
  function automatic bit unfilter_byte(input int c, input stream_item_t it,
                                       output pix_result_t res);
    int unsigned len, stp, pos, hp;
    logic [7:0] left, up, corner, pred, rec;
    bit last;
    len    = row_len_of(c);
    stp    = px_step_of(c);
    left   = '0;
    up     = '0;
    corner = '0;
    res    = '0;
    if (it.start) begin
      top_row[c]   = 1'b1;
      want_code[c] = 1'b1;
      halted[c]    = 1'b0;
      col[c]       = 0;
    end
    if (halted[c]) return 1'b0;
    if (want_code[c]) begin
      if (it.data > FILT_CODE_MAX) begin
        halted[c] = 1'b1;
        res.bad   = 1'b1;
        return 1'b1;
      end
      row_filt[c]  = filt_t'(it.data[2:0]);
      want_code[c] = 1'b0;
      col[c]       = 0;
      return 1'b0;
    end
    pos = col[c];
    if (pos >= MAX_ROW_BYTES) pos = MAX_ROW_BYTES - 1;
    if (!top_row[c]) up = line_mem[c][pos];
    if (pos >= stp) begin
      hp   = (pos - stp) % HIST_DEPTH;
      left = left_hist[c][hp];
      if (!top_row[c]) corner = corner_hist[c][hp];
    end
    case (row_filt[c])
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = 8'((9'(left) + 9'(up)) >> 1);
      FILT_PAETH: pred = paeth_select(left, up, corner);
      default:    pred = '0;
    endcase
    rec = it.data + pred;
    corner_hist[c][pos % HIST_DEPTH] = up;
    left_hist[c][pos % HIST_DEPTH]   = rec;
    line_mem[c][pos]   = rec;
    line_valid[c][pos] = 1'b1;
    last = (pos + 1 >= len);
    if (last) begin
      want_code[c] = 1'b1;
      top_row[c]   = 1'b0;
      col[c]       = 0;
    end else begin
      col[c] = pos + 1;
    end
    res.pix  = rec;
    res.last = last;
    return 1'b1;
  endfunction

  // a data byte on a later row whose line store entry was never filled
  function automatic bit hits_blank_line(input int c, input stream_item_t it);
    int unsigned pos;
    if (it.start || halted[c] || want_code[c] || top_row[c]) return 1'b0;
    pos = col[c];
    if (pos >= MAX_ROW_BYTES) pos = MAX_ROW_BYTES - 1;
    return !line_valid[c][pos];
  endfunction

  // a new row must begin an image when it cannot follow on from the stream state
  function automatic bit needs_restart();
    return halted[PLAN] || !want_code[PLAN] ||
           (!top_row[PLAN] && !line_valid[PLAN][row_len_of(PLAN) - 1]);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued items on the falling edge, holds them until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      if (queued_bytes.size() > 0 && $urandom_range(99) >= gap_pct) begin
        next_item = queued_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_item.data;
        in_tuser  <= next_item.start;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    // receiver back-pressure, drawn fresh every cycle
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: all handshakes sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      // register writes only happen while idle, so the order with items is fixed
      if (cfg_valid && cfg_ready) set_reg(LIVE, cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        took_item.data  = in_tdata;
        took_item.start = in_tuser[0];
        if (unfilter_byte(LIVE, took_item, due_pix)) rebuilt_due.push_back(due_pix);
      end
      if (out_tvalid && out_tready) begin
        seen_pix.pix  = out_tdata;
        seen_pix.last = out_tlast;
        seen_pix.bad  = out_tuser[0];
        if (rebuilt_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("%0t: unexpected result byte %02h last %0b bad %0b",
                     $realtime, seen_pix.pix, seen_pix.last, seen_pix.bad);
        end else begin
          due_pix = rebuilt_due.pop_front();
          if (seen_pix !== due_pix) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
              $display("%0t: want byte %02h last %0b bad %0b, got byte %02h last %0b bad %0b",
                       $realtime, due_pix.pix, due_pix.last, due_pix.bad,
                       seen_pix.pix, seen_pix.last, seen_pix.bad);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // queue one item; a byte that would read an unfilled line store entry
  // is turned into an image start instead
  task automatic queue_byte(input logic [7:0] d, input logic s);
    stream_item_t it;
    it.data  = d;
    it.start = s;
    if (hits_blank_line(PLAN, it)) it.start = 1'b1;
    // dropped bytes after a bad code do not count as real traffic
    if (!(halted[PLAN] && !it.start)) fed_bytes++;
    void'(unfilter_byte(PLAN, it, sink_pix));
    queued_bytes.push_back(it);
  endtask

  // filter code followed by a full row of random filtered bytes
  task automatic queue_row(input logic [7:0] code, input logic s);
    int unsigned n;
    queue_byte(code, s);
    n = row_len_of(PLAN);
    for (int unsigned i = 0; i < n; i++) queue_byte(8'($urandom_range(255)), 1'b0);
  endtask

  // wait until every item is taken and every result is back, then let the pipe drain
  task automatic settle();
    while (queued_bytes.size() != 0 || in_tvalid || rebuilt_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [ROW_BYTES_W-1:0] val);
    set_reg(PLAN, idx, val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // short rows mostly, with the zero and one corner cases and a few longer rows
  task automatic pick_random_config();
    int unsigned rb;
    case ($urandom_range(9))
      0:       rb = 0;
      1:       rb = 1;
      7, 8:    rb = $urandom_range(25, 120);
      default: rb = $urandom_range(2, 24);
    endcase
    write_reg(REG_ROW_BYTES, ROW_BYTES_W'(rb));
    // upper data bits are ignored by the step register but still toggled
    write_reg(REG_PIXEL_STEP, {10'($urandom_range(1023)), 4'($urandom_range(15))});
  endtask

  // mostly well-formed rows, plus bad codes, cut rows and stray items
  task automatic random_traffic(input int n_items);
    int base, r, n;
    logic [7:0] code;
    base = fed_bytes;
    while (fed_bytes - base < n_items) begin
      r = $urandom_range(99);
      if (r < 82) begin
        code = 8'($urandom_range(4));
        queue_row(code, needs_restart() || $urandom_range(9) == 0);
      end else if (r < 88) begin
        // bad filter code then bytes that must be dropped
        queue_byte(8'($urandom_range(255, 5)), 1'($urandom_range(1)));
        n = $urandom_range(4);
        for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(255)), 1'b0);
      end else if (r < 94) begin
        // row cut short; the next row restarts the image
        queue_byte(8'($urandom_range(4)), needs_restart());
        n = $urandom_range(row_len_of(PLAN) - 1);
        for (int i = 0; i < n; i++) queue_byte(8'($urandom_range(255)), 1'b0);
      end else begin
        queue_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_shadow(LIVE);
    reset_shadow(PLAN);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows, three bytes each, left neighbour two bytes back
    write_reg(REG_ROW_BYTES, 14'd3);
    write_reg(REG_PIXEL_STEP, 14'd2);
    queue_byte(8'(FILT_NONE), 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'(FILT_SUB), 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'(FILT_UP), 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'(FILT_AVG), 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'(FILT_PAETH), 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h10, 1'b0);
    queue_byte(8'hC4, 1'b0);
    // bad code, a dropped byte, a bad code carried by an image start
    queue_byte(FILT_CODE_MAX + 8'd1, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // recovery on a fresh image: above and corner read as zero
    queue_row(8'(FILT_PAETH), 1'b1);
    settle();

    // row length shrunk in the middle of a row ends that row early
    write_reg(REG_ROW_BYTES, 14'd6);
    queue_byte(8'(FILT_SUB), 1'b1);
    for (int i = 0; i < 4; i++) queue_byte(8'($urandom_range(255)), 1'b0);
    settle();
    write_reg(REG_ROW_BYTES, 14'd2);
    queue_byte(8'($urandom_range(255)), 1'b0);
    queue_row(8'(FILT_AVG), 1'b0);
    settle();

    // zero in both registers acts as one
    write_reg(REG_ROW_BYTES, 14'd0);
    write_reg(REG_PIXEL_STEP, 14'h3FF0);
    queue_row(8'(FILT_SUB), 1'b0);
    queue_row(8'(FILT_PAETH), 1'b0);
    queue_row(8'(FILT_UP), 1'b0);
    settle();

    // oversize length and step saturate: a long cut row never ends early
    write_reg(REG_ROW_BYTES, 14'h3FFF);
    write_reg(REG_PIXEL_STEP, 14'h000F);
    queue_byte(8'(FILT_PAETH), 1'b1);
    for (int i = 0; i < LONG_CUT_BYTES; i++) queue_byte(8'($urandom_range(255)), 1'b0);
    settle();

    // random traffic under each idling pattern, three settings per pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 67; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 67; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        settle();
        pick_random_config();
        random_traffic(117);
      end
    end

    settle();
    if (mismatch_cnt == 0 && rebuilt_due.size() == 0) begin
      $display("tb_png_row_unfilter_top: done, clean");
    end else begin
      $display("tb_png_row_unfilter_top: done, errors");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("tb_png_row_unfilter_top: done, errors");
    $finish;
  end

endmodule
